// ----- rtl/abfa_pkg.sv -----
// ----------------------------------------------------------------------------
// abfa_pkg
// Shared constants for the affine background fetch address generator:
// operation and result codes, register indexes, reset values, memory bases.
// ----------------------------------------------------------------------------
`default_nettype none

package abfa_pkg;

    // video memory base address
    localparam logic [31:0] VRAM_BASE = 32'h0600_0000;

    // input operation codes
    localparam logic [1:0] OP_RELOAD    = 2'd0;
    localparam logic [1:0] OP_PIXEL     = 2'd1;
    localparam logic [1:0] OP_MAP_ENTRY = 2'd2;
    localparam logic [1:0] OP_LINE_END  = 2'd3;

    // result kinds
    localparam logic [1:0] KIND_SKIP   = 2'd0;
    localparam logic [1:0] KIND_MAP    = 2'd1;
    localparam logic [1:0] KIND_INDEX  = 2'd2;
    localparam logic [1:0] KIND_DIRECT = 2'd3;

    // register indexes
    localparam logic [2:0] REG_BG_CONTROL   = 3'd0;
    localparam logic [2:0] REG_BASE_EXT     = 3'd1;
    localparam logic [2:0] REG_DX_PER_PIXEL = 3'd2;
    localparam logic [2:0] REG_DY_PER_PIXEL = 3'd3;
    localparam logic [2:0] REG_DX_PER_LINE  = 3'd4;
    localparam logic [2:0] REG_DY_PER_LINE  = 3'd5;
    localparam logic [2:0] REG_START_X      = 3'd6;
    localparam logic [2:0] REG_START_Y      = 3'd7;

    // register reset values
    localparam logic [15:0] RST_DX_PER_PIXEL = 16'h0100;
    localparam logic [15:0] RST_DY_PER_LINE  = 16'h0100;

    // smallest map/bitmap side is 128 pixels
    localparam logic [3:0] MIN_SIZE_LOG2 = 4'd7;

endpackage

`default_nettype wire

// ----- rtl/affine_background_fetch_address.sv -----
// ----------------------------------------------------------------------------
// affine_background_fetch_address
// Fetch address generator for one rotation/scaling background layer.
// ----------------------------------------------------------------------------
// The block accepts one item per clock unless a stalled result side holds
// it. A pixel or map-entry item passes the coordinate stage and then the
// output register before the result side sees it. Throughput is one item per
// clock while the result side is ready; a stalled result side holds the input
// once both the coordinate stage and the output register are full. Pixel
// items give the texture coordinate as (reference + step * pixel) >> 8; the
// first stage does the 16x8 multiply-add per axis, the second does the range
// check and builds the byte address. Reload and line-end items update the
// reference point at the transfer and give no result; a map-entry item in
// bitmap mode gives none either. Registers may only be written while no item
// is in flight.
`default_nettype none

module affine_background_fetch_address (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // configuration write port
    input  wire logic        cfg_wr_en,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [27:0] cfg_data,
    // input stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,   // pixel [7:0], map_entry [23:8]
    input  wire logic [1:0]  s_axis_tuser,   // op [1:0]
    // result stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [39:0]      m_axis_tdata,   // pixel_out [7:0], address [39:8]
    output logic [1:0]       m_axis_tuser    // kind [1:0]
);

    // configuration registers
    logic [15:0] bg_control_reg;
    logic [5:0]  base_ext_reg;
    logic [15:0] dx_pixel_reg;
    logic [15:0] dy_pixel_reg;
    logic [15:0] dx_line_reg;
    logic [15:0] dy_line_reg;
    logic [27:0] start_x_reg;
    logic [27:0] start_y_reg;

    // reference point
    logic [31:0] ref_x_reg;
    logic [31:0] ref_y_reg;

    // coordinate stage
    logic        st1_valid_reg;
    logic        st1_entry_reg;
    logic [7:0]  st1_pixel_reg;
    logic [15:0] st1_map_entry_reg;
    logic [31:8] st1_sum_x_reg;
    logic [31:8] st1_sum_y_reg;

    // output stage
    logic        out_valid_reg;
    logic [7:0]  out_pixel_reg;
    logic [1:0]  out_kind_reg;
    logic [31:0] out_addr_reg;

    logic        in_xfer;
    logic        st1_advance;
    logic        out_free;
    logic [1:0]  in_op;
    logic [7:0]  in_pixel;
    logic        bitmap_mode;
    logic        in_makes_result;
    logic [23:0] prod_x;
    logic [23:0] prod_y;
    logic [31:0] sum_x_next;
    logic [31:0] sum_y_next;

    logic [1:0]  size_sel;
    logic [3:0]  lg_x;
    logic [3:0]  lg_y;
    logic [23:0] cx;
    logic [23:0] cy;
    logic        in_range;
    logic [2:0]  row;
    logic [2:0]  col;
    logic [31:0] bitmap_base;
    logic [31:0] map_base;
    logic [31:0] char_base;
    logic [31:0] bitmap_index;
    logic [30:0] map_index;
    logic [1:0]  kind_next;
    logic [31:0] addr_next;

    // handshake and stall chain
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign st1_advance   = st1_valid_reg && out_free;
    assign s_axis_tready = !st1_valid_reg || out_free;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;

    assign in_op       = s_axis_tuser;
    assign in_pixel    = s_axis_tdata[7:0];
    assign bitmap_mode = bg_control_reg[7];

    // items that produce a result
    assign in_makes_result = (in_op == abfa_pkg::OP_PIXEL)
                          || ((in_op == abfa_pkg::OP_MAP_ENTRY) && !bitmap_mode);

    // per-pixel multiply-add, wraps at 32 bits
    assign prod_x = 24'($signed(dx_pixel_reg) * $signed({1'b0, in_pixel}));
    assign prod_y = 24'($signed(dy_pixel_reg) * $signed({1'b0, in_pixel}));
    assign sum_x_next = ref_x_reg + {{8{prod_x[23]}}, prod_x};
    assign sum_y_next = ref_y_reg + {{8{prod_y[23]}}, prod_y};

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bg_control_reg <= '0;
            base_ext_reg   <= '0;
            dx_pixel_reg   <= abfa_pkg::RST_DX_PER_PIXEL;
            dy_pixel_reg   <= '0;
            dx_line_reg    <= '0;
            dy_line_reg    <= abfa_pkg::RST_DY_PER_LINE;
            start_x_reg    <= '0;
            start_y_reg    <= '0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                abfa_pkg::REG_BG_CONTROL:   bg_control_reg <= cfg_data[15:0];
                abfa_pkg::REG_BASE_EXT:     base_ext_reg   <= cfg_data[5:0];
                abfa_pkg::REG_DX_PER_PIXEL: dx_pixel_reg   <= cfg_data[15:0];
                abfa_pkg::REG_DY_PER_PIXEL: dy_pixel_reg   <= cfg_data[15:0];
                abfa_pkg::REG_DX_PER_LINE:  dx_line_reg    <= cfg_data[15:0];
                abfa_pkg::REG_DY_PER_LINE:  dy_line_reg    <= cfg_data[15:0];
                abfa_pkg::REG_START_X:      start_x_reg    <= cfg_data;
                abfa_pkg::REG_START_Y:      start_y_reg    <= cfg_data;
                default:                    ;
            endcase
        end
    end

    // reference point update on reload and line end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_x_reg <= '0;
            ref_y_reg <= '0;
        end
        else if (in_xfer)
        begin
            case (in_op)
                abfa_pkg::OP_RELOAD:
                begin
                    ref_x_reg <= {{4{start_x_reg[27]}}, start_x_reg};
                    ref_y_reg <= {{4{start_y_reg[27]}}, start_y_reg};
                end
                abfa_pkg::OP_LINE_END:
                begin
                    ref_x_reg <= ref_x_reg + {{16{dx_line_reg[15]}}, dx_line_reg};
                    ref_y_reg <= ref_y_reg + {{16{dy_line_reg[15]}}, dy_line_reg};
                end
                default: ;
            endcase
        end
    end

    // stage valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st1_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_axis_tready)
                st1_valid_reg <= in_xfer && in_makes_result;
            if (out_free)
                out_valid_reg <= st1_valid_reg;
        end
    end

    // coordinate stage payload
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            st1_entry_reg     <= (in_op == abfa_pkg::OP_MAP_ENTRY);
            st1_pixel_reg     <= in_pixel;
            st1_map_entry_reg <= s_axis_tdata[23:8];
            st1_sum_x_reg     <= sum_x_next[31:8];
            st1_sum_y_reg     <= sum_y_next[31:8];
        end
    end

    // map or bitmap size as log2 of each side
    assign size_sel = bg_control_reg[15:14];
    always_comb
    begin
        if (bitmap_mode)
        begin
            case (size_sel)
                2'd0:    begin lg_x = 4'd7; lg_y = 4'd7; end
                2'd1:    begin lg_x = 4'd8; lg_y = 4'd8; end
                2'd2:    begin lg_x = 4'd9; lg_y = 4'd8; end
                default: begin lg_x = 4'd9; lg_y = 4'd9; end
            endcase
        end
        else
        begin
            lg_x = abfa_pkg::MIN_SIZE_LOG2 + {2'b00, size_sel};
            lg_y = lg_x;
        end
    end

    // range check on the texture coordinate
    assign cx = st1_sum_x_reg[31:8];
    assign cy = st1_sum_y_reg[31:8];
    assign in_range = !st1_sum_x_reg[31] && !st1_sum_y_reg[31]
                   && ((cx >> lg_x) == 24'd0) && ((cy >> lg_y) == 24'd0);

    // base addresses
    assign bitmap_base = abfa_pkg::VRAM_BASE + {13'd0, bg_control_reg[12:8], 14'd0};
    assign map_base    = abfa_pkg::VRAM_BASE + {16'd0, bg_control_reg[12:8], 11'd0}
                       + {13'd0, base_ext_reg[5:3], 16'd0};
    assign char_base   = abfa_pkg::VRAM_BASE + {14'd0, bg_control_reg[5:2], 14'd0}
                       + {13'd0, base_ext_reg[2:0], 16'd0};

    // linear offsets; sides are powers of two so products are shifts
    assign bitmap_index = ({8'd0, cy} << lg_x) | {8'd0, cx};
    assign map_index    = ({10'd0, cy[23:3]} << (lg_x - 4'd3)) + {10'd0, cx[23:3]};

    // flipped row and column inside the character
    assign row = cy[2:0] ^ {3{st1_map_entry_reg[11]}};
    assign col = cx[2:0] ^ {3{st1_map_entry_reg[10]}};

    // result kind and address
    always_comb
    begin
        kind_next = abfa_pkg::KIND_SKIP;
        addr_next = '0;
        if (in_range)
        begin
            if (bitmap_mode)
            begin
                if (bg_control_reg[2])
                begin
                    kind_next = abfa_pkg::KIND_DIRECT;
                    addr_next = bitmap_base + {bitmap_index[30:0], 1'b0};
                end
                else
                begin
                    kind_next = abfa_pkg::KIND_INDEX;
                    addr_next = bitmap_base + bitmap_index;
                end
            end
            else if (!st1_entry_reg)
            begin
                kind_next = abfa_pkg::KIND_MAP;
                addr_next = map_base + {map_index, 1'b0};
            end
            else
            begin
                kind_next = abfa_pkg::KIND_INDEX;
                addr_next = char_base + {16'd0, st1_map_entry_reg[9:0], row, col};
            end
        end
    end

    // output register
    always_ff @(posedge clk)
    begin
        if (st1_advance)
        begin
            out_pixel_reg <= st1_pixel_reg;
            out_kind_reg  <= kind_next;
            out_addr_reg  <= addr_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_addr_reg, out_pixel_reg};
    assign m_axis_tuser  = out_kind_reg;

endmodule

`default_nettype wire
